// ===== sv/exr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Euler XYZ vertex rotator.
// No dependencies; imported by exr_rot_step and euler_xyz_vertex_rotator.
package exr_pkg;

    localparam int COEF_WIDTH    = 18;
    localparam int NUM_REGS      = 6;
    localparam int CFG_IDX_WIDTH = 3;

    // Reset values of the coefficient registers: identity rotation (cos = 1.0, sin = 0)
    localparam logic signed [COEF_WIDTH-1:0] COS_RESET = 18'sd65536;
    localparam logic signed [COEF_WIDTH-1:0] SIN_RESET = 18'sd0;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_COS_X = 3'd0,
        REG_SIN_X = 3'd1,
        REG_COS_Y = 3'd2,
        REG_SIN_Y = 3'd3,
        REG_COS_Z = 3'd4,
        REG_SIN_Z = 3'd5
    } cfg_reg_t;

endpackage

// ===== sv/exr_rot_step.sv =====
`timescale 1ns / 1ps
// One planar rotation step: a' = c*a - s*b, b' = s*a + c*b, rounded and saturated.
// Two register stages (products, then sum/round/saturate). Depends on exr_pkg.
module exr_rot_step #(
    parameter int COORD_WIDTH    = 32,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  logic signed [COORD_WIDTH-1:0] a_in,
    input  logic signed [COORD_WIDTH-1:0] b_in,
    input  logic signed [COORD_WIDTH-1:0] pass_in,
    input  exr_pkg::coef_t                cos_val,
    input  exr_pkg::coef_t                sin_val,
    output logic                          valid_out,
    output logic signed [COORD_WIDTH-1:0] a_out,
    output logic signed [COORD_WIDTH-1:0] b_out,
    output logic signed [COORD_WIDTH-1:0] pass_out
);
    import exr_pkg::*;

    localparam int PW = COORD_WIDTH + COEF_WIDTH;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] RND = SW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [COORD_WIDTH-1:0] MAX_V = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MIN_V = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // stage 1: products
    logic                          v1_reg;
    logic signed [PW-1:0]          ca_reg, sb_reg, sa_reg, cb_reg;
    logic signed [COORD_WIDTH-1:0] p1_reg;
    // stage 2: rounded, saturated sums
    logic                          v2_reg;
    logic signed [COORD_WIDTH-1:0] a2_reg, b2_reg, p2_reg;
    logic signed [COORD_WIDTH-1:0] a2_next, b2_next;

    logic signed [SW-1:0] sum_a, sum_b, sh_a, sh_b;
    logic [SW-COORD_WIDTH:0] hi_a, hi_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ca_reg <= PW'(cos_val) * PW'(a_in);
        sb_reg <= PW'(sin_val) * PW'(b_in);
        sa_reg <= PW'(sin_val) * PW'(a_in);
        cb_reg <= PW'(cos_val) * PW'(b_in);
        p1_reg <= pass_in;
        a2_reg <= a2_next;
        b2_reg <= b2_next;
        p2_reg <= p1_reg;
    end

    always_comb
    begin
        sum_a = SW'(ca_reg) - SW'(sb_reg) + RND;
        sum_b = SW'(sa_reg) + SW'(cb_reg) + RND;
        sh_a  = sum_a >>> COEF_FRAC_BITS;
        sh_b  = sum_b >>> COEF_FRAC_BITS;
        hi_a  = sh_a[SW-1:COORD_WIDTH-1];
        hi_b  = sh_b[SW-1:COORD_WIDTH-1];
        // in range when the bits above the sign all match it
        if ((&hi_a) || !(|hi_a))
            a2_next = sh_a[COORD_WIDTH-1:0];
        else
            a2_next = sh_a[SW-1] ? MIN_V : MAX_V;
        if ((&hi_b) || !(|hi_b))
            b2_next = sh_b[COORD_WIDTH-1:0];
        else
            b2_next = sh_b[SW-1] ? MIN_V : MAX_V;
    end

    assign valid_out = v2_reg;
    assign a_out     = a2_reg;
    assign b_out     = b2_reg;
    assign pass_out  = p2_reg;

    a_valid_delay: assert property (@(posedge clk) disable iff (!rst_n)
        valid_in |-> ##2 valid_out)
        else $error("rot step lost a valid");

    a_pass_delay: assert property (@(posedge clk) disable iff (!rst_n)
        valid_in ##2 valid_out |-> pass_out == $past(pass_in, 2))
        else $error("pass coordinate misaligned with its item");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out |-> $past(valid_in, 2))
        else $error("rot step produced an item from nothing");

endmodule

// ===== sv/euler_xyz_vertex_rotator.sv =====
`timescale 1ns / 1ps
// Euler XYZ vertex rotator, top level: coefficient registers and three rotation steps.
// Depends on exr_pkg and exr_rot_step.
//
// Rotates one signed fixed-point vertex per clock, first about X, then Y, then Z,
// using the cosine/sine pairs in six coefficient registers (Q1.16, reset to identity).
// A vertex is taken on any cycle where start is high; busy never rises, so a new
// vertex may follow every cycle. The rotated vertex appears on x_out/y_out/z_out with
// done high for one cycle, after its transfer has passed through the three steps, each
// a multiply stage followed by a sum/round/saturate stage. Results cannot be
// held off; the receiver must take them when done is high. Coefficient writes on the
// cfg channel are always ready and must only be made while no vertex is in flight.
module euler_xyz_vertex_rotator #(
    parameter int COORD_WIDTH    = 32,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [COORD_WIDTH-1:0]         x_in,
    input  logic signed [COORD_WIDTH-1:0]         y_in,
    input  logic signed [COORD_WIDTH-1:0]         z_in,
    output logic                                  done,
    output logic signed [COORD_WIDTH-1:0]         x_out,
    output logic signed [COORD_WIDTH-1:0]         y_out,
    output logic signed [COORD_WIDTH-1:0]         z_out,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [exr_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [exr_pkg::COEF_WIDTH-1:0]        cfg_data
);
    import exr_pkg::*;

    coef_t coef_reg [NUM_REGS];

    logic                          in_xfer;
    logic                          vx, vy;
    logic signed [COORD_WIDTH-1:0] y1, z1, x1p;
    logic signed [COORD_WIDTH-1:0] z2, x2, y1p;

    assign busy      = 1'b0;    // fully pipelined, never stalls
    assign cfg_ready = 1'b1;
    assign in_xfer   = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[REG_COS_X] <= COS_RESET;
            coef_reg[REG_SIN_X] <= SIN_RESET;
            coef_reg[REG_COS_Y] <= COS_RESET;
            coef_reg[REG_SIN_Y] <= SIN_RESET;
            coef_reg[REG_COS_Z] <= COS_RESET;
            coef_reg[REG_SIN_Z] <= SIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COS_X: coef_reg[REG_COS_X] <= cfg_data;
                REG_SIN_X: coef_reg[REG_SIN_X] <= cfg_data;
                REG_COS_Y: coef_reg[REG_COS_Y] <= cfg_data;
                REG_SIN_Y: coef_reg[REG_SIN_Y] <= cfg_data;
                REG_COS_Z: coef_reg[REG_COS_Z] <= cfg_data;
                REG_SIN_Z: coef_reg[REG_SIN_Z] <= cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // about X: (y, z) -> (y1, z1)
    exr_rot_step #(.COORD_WIDTH(COORD_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_step_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (in_xfer),
        .a_in     (y_in),
        .b_in     (z_in),
        .pass_in  (x_in),
        .cos_val  (coef_reg[REG_COS_X]),
        .sin_val  (coef_reg[REG_SIN_X]),
        .valid_out(vx),
        .a_out    (y1),
        .b_out    (z1),
        .pass_out (x1p)
    );

    // about Y: (z1, x) -> (z2, x2)
    exr_rot_step #(.COORD_WIDTH(COORD_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_step_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (vx),
        .a_in     (z1),
        .b_in     (x1p),
        .pass_in  (y1),
        .cos_val  (coef_reg[REG_COS_Y]),
        .sin_val  (coef_reg[REG_SIN_Y]),
        .valid_out(vy),
        .a_out    (z2),
        .b_out    (x2),
        .pass_out (y1p)
    );

    // about Z: (x2, y1) -> (x3, y3)
    exr_rot_step #(.COORD_WIDTH(COORD_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_step_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (vy),
        .a_in     (x2),
        .b_in     (y1p),
        .pass_in  (z2),
        .cos_val  (coef_reg[REG_COS_Z]),
        .sin_val  (coef_reg[REG_SIN_Z]),
        .valid_out(done),
        .a_out    (x_out),
        .b_out    (y_out),
        .pass_out (z_out)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> ##6 done)
        else $error("vertex transfer without result six cycles later");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_xfer, 6))
        else $error("result without a matching vertex transfer");

    a_bad_index: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index >= CFG_IDX_WIDTH'(NUM_REGS))
        |=> $stable(coef_reg[REG_COS_X]) && $stable(coef_reg[REG_SIN_X])
            && $stable(coef_reg[REG_COS_Y]) && $stable(coef_reg[REG_SIN_Y])
            && $stable(coef_reg[REG_COS_Z]) && $stable(coef_reg[REG_SIN_Z]))
        else $error("write to unmapped index changed a coefficient");

endmodule
